// ===== hdl/chacha20_stream_cipher_defines.svh =====
// assertion macros for the chacha20 stream cipher block
// used by the top level, expects clk_i and rst_ni in scope
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CC20_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CC20_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CC20_ASSERT(label, prop, msg)
`define CC20_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== hdl/cc20_pkg.sv =====
// shared types for the chacha20 stream cipher: request payloads, queue entry,
// configuration register group and register indexes; no dependencies
package cc20_pkg;

  typedef enum logic [2:0] {
    RegKey0    = 3'd0,
    RegKey1    = 3'd1,
    RegKey2    = 3'd2,
    RegKey3    = 3'd3,
    RegNonceLo = 3'd4,
    RegNonceHi = 3'd5,
    RegCounter = 3'd6
  } reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       new_msg;
    logic       new_block;
  } qent_t;

  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [63:0] key2;
    logic [63:0] key3;
    logic [63:0] nonce_low;
    logic [31:0] nonce_high;
    logic [31:0] initial_counter;
  } cfg_t;

endpackage

// ===== hdl/cc20_front.sv =====
// front end: accepts requests and tags message and block starts
// depends on cc20_pkg
module cc20_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  cc20_pkg::in_t in_data_i,
  output logic          in_stall_o,
  input  logic          full_i,
  output logic          push_o,
  output cc20_pkg::qent_t entry_o
);

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned PosW = $clog2(BlockBytes);

  logic [PosW-1:0] pos_q, pos_d;
  logic            active_q, active_d;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    entry_o.data_byte = in_data_i.data_byte;
    entry_o.last_byte = in_data_i.last_byte;
    entry_o.new_msg   = !active_q;
    entry_o.new_block = (pos_q == '0);
  end

  always_comb begin
    pos_d    = pos_q;
    active_d = active_q;
    if (push_o) begin
      if (in_data_i.last_byte) begin
        pos_d    = '0;
        active_d = 1'b0;
      end else begin
        pos_d    = pos_q + 1'b1;
        active_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      active_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== hdl/cc20_queue.sv =====
// short request queue between front and back end
// depends on cc20_pkg; Depth must be at least 2
module cc20_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cc20_pkg::qent_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cc20_pkg::qent_t entry_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cc20_pkg::qent_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hdl/cc20_back.sv =====
// back end: block function sequencer, keystream shift register and output register
// depends on cc20_pkg
module cc20_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cc20_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  cc20_pkg::qent_t q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  output cc20_pkg::out_t  out_data_o,
  input  logic            out_stall_i
);

  localparam int unsigned Rounds = 20;
  localparam int unsigned RndW = $clog2(Rounds);
  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef logic [15:0][31:0] state_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRound = 4'b0010,
    StFinal = 4'b0100,
    StEmit  = 4'b1000
  } st_e;

  function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t init_state(cc20_pkg::cfg_t c, logic [31:0] ctr);
    state_t s;
    s[0]  = Sigma0;
    s[1]  = Sigma1;
    s[2]  = Sigma2;
    s[3]  = Sigma3;
    s[4]  = c.key0[31:0];
    s[5]  = c.key0[63:32];
    s[6]  = c.key1[31:0];
    s[7]  = c.key1[63:32];
    s[8]  = c.key2[31:0];
    s[9]  = c.key2[63:32];
    s[10] = c.key3[31:0];
    s[11] = c.key3[63:32];
    s[12] = ctr;
    s[13] = c.nonce_low[31:0];
    s[14] = c.nonce_low[63:32];
    s[15] = c.nonce_high;
    return s;
  endfunction

  // one line of the quarter round, applied to all four lanes of a column or diagonal round
  function automatic state_t qstep(state_t s, logic [1:0] ph, logic diag);
    state_t     r;
    logic [1:0] lb, lc, ld;
    logic [3:0] ia, ib, ic, id;
    logic [31:0] x;
    r = s;
    for (int l = 0; l < 4; l++) begin
      lb = 2'(l) + {1'b0, diag};
      lc = 2'(l) + {diag, 1'b0};
      ld = 2'(l) + {diag, diag};
      ia = {2'b00, 2'(l)};
      ib = {2'b01, lb};
      ic = {2'b10, lc};
      id = {2'b11, ld};
      unique case (ph)
        2'd0: begin
          x     = s[ia] + s[ib];
          r[ia] = x;
          r[id] = rotl32(s[id] ^ x, 16);
        end
        2'd1: begin
          x     = s[ic] + s[id];
          r[ic] = x;
          r[ib] = rotl32(s[ib] ^ x, 12);
        end
        2'd2: begin
          x     = s[ia] + s[ib];
          r[ia] = x;
          r[id] = rotl32(s[id] ^ x, 8);
        end
        2'd3: begin
          x     = s[ic] + s[id];
          r[ic] = x;
          r[ib] = rotl32(s[ib] ^ x, 7);
        end
        default: begin
          r = s;
        end
      endcase
    end
    return r;
  endfunction

  st_e             st_q, st_d;
  state_t          state_q, state_d;
  state_t          init_w;
  logic [1:0]      step_q, step_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic [31:0]     ctr_q, ctr_d;
  logic [7:0]      hold_data_q, hold_data_d;
  logic            hold_last_q, hold_last_d;
  logic            out_valid_q, out_valid_d;
  cc20_pkg::out_t  out_q, out_d;
  logic            out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign init_w      = init_state(cfg_i, ctr_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [31:0] ctr_use;
    ctr_use     = ctr_q;
    st_d        = st_q;
    state_d     = state_q;
    step_d      = step_q;
    rnd_d       = rnd_q;
    ctr_d       = ctr_q;
    hold_data_d = hold_data_q;
    hold_last_d = hold_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_entry_i.new_block) begin
            ctr_use     = q_entry_i.new_msg ? cfg_i.initial_counter : ctr_q;
            ctr_d       = ctr_use;
            state_d     = init_state(cfg_i, ctr_use);
            hold_data_d = q_entry_i.data_byte;
            hold_last_d = q_entry_i.last_byte;
            step_d      = '0;
            rnd_d       = '0;
            st_d        = StRound;
          end else begin
            out_valid_d    = 1'b1;
            out_d.out_byte = q_entry_i.data_byte ^ state_q[0][7:0];
            out_d.out_last = q_entry_i.last_byte;
            state_d        = state_q >> 8;
          end
        end
      end
      StRound: begin
        state_d = qstep(state_q, step_q, rnd_q[0]);
        step_d  = step_q + 1'b1;
        if (step_q == 2'd3) begin
          if (rnd_q == RndW'(Rounds - 1)) begin
            rnd_d = '0;
            st_d  = StFinal;
          end else begin
            rnd_d = rnd_q + 1'b1;
          end
        end
      end
      StFinal: begin
        for (int i = 0; i < 16; i++) begin
          state_d[i] = state_q[i] + init_w[i];
        end
        ctr_d = ctr_q + 1'b1;
        st_d  = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.out_byte = hold_data_q ^ state_q[0][7:0];
          out_d.out_last = hold_last_q;
          state_d        = state_q >> 8;
          st_d           = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    state_q     <= state_d;
    hold_data_q <= hold_data_d;
    hold_last_q <= hold_last_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      step_q      <= '0;
      rnd_q       <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      rnd_q       <= rnd_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/chacha20_stream_cipher.sv =====
// chacha20 stream cipher top level: config registers, front end, queue, back end
// depends on cc20_pkg, cc20_front, cc20_queue, cc20_back and the defines header
// path: a request passes the queue and then the output register inside a block; at a
// block start the back end first runs the round and final states; each block gives
// 64 keystream bytes, and the round unit does one quarter-round line per cycle
// reset: asynchronous active low, clears control and config registers, queue pointers and position; no clearing pass
`include "chacha20_stream_cipher_defines.svh"

module chacha20_stream_cipher #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  cc20_pkg::in_t  in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output cc20_pkg::out_t out_data_o,
  input  logic           out_stall_i,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready
);

  cc20_pkg::cfg_t  cfg_q;
  logic [2:0]      reg_idx;
  logic            cfg_we;
  logic            push;
  logic            full;
  logic            q_valid;
  logic            q_pop;
  cc20_pkg::qent_t push_entry;
  cc20_pkg::qent_t q_entry;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        cc20_pkg::RegKey0:    cfg_q.key0            <= pwdata;
        cc20_pkg::RegKey1:    cfg_q.key1            <= pwdata;
        cc20_pkg::RegKey2:    cfg_q.key2            <= pwdata;
        cc20_pkg::RegKey3:    cfg_q.key3            <= pwdata;
        cc20_pkg::RegNonceLo: cfg_q.nonce_low       <= pwdata;
        cc20_pkg::RegNonceHi: cfg_q.nonce_high      <= pwdata[31:0];
        cc20_pkg::RegCounter: cfg_q.initial_counter <= pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cc20_pkg::RegKey0:    prdata = cfg_q.key0;
      cc20_pkg::RegKey1:    prdata = cfg_q.key1;
      cc20_pkg::RegKey2:    prdata = cfg_q.key2;
      cc20_pkg::RegKey3:    prdata = cfg_q.key3;
      cc20_pkg::RegNonceLo: prdata = cfg_q.nonce_low;
      cc20_pkg::RegNonceHi: prdata = {32'd0, cfg_q.nonce_high};
      cc20_pkg::RegCounter: prdata = {32'd0, cfg_q.initial_counter};
      default:              prdata = '0;
    endcase
  end

  cc20_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  cc20_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  cc20_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // queue bookkeeping as seen from both sides
  `CC20_ASSERT(a_pop_needs_entry, !q_pop || q_valid, "pop from an empty queue")
  `CC20_ASSERT(a_stall_means_full, !in_stall_o || q_valid, "input stalled with empty queue")
  `CC20_ASSERT_NEXT(a_accept_fills, in_valid_i && !in_stall_o, q_valid,
                    "accepted request missing from queue")

endmodule
